FILE: rtl/core/cafl_pkg.sv
// Package for the 8-bit ALU with flag register: operation codes and the flag bundle.
// Depends on nothing; imported by cafl_alu, cpu_alu_with_flags_core, alu_flags_checker and tb_top.
package cafl_pkg;

  localparam int unsigned CmdWidth  = 5;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned IdxWidth  = 3;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD   = 5'd0,
    CMD_ADC   = 5'd1,
    CMD_SUB   = 5'd2,
    CMD_SBC   = 5'd3,
    CMD_AND   = 5'd4,
    CMD_XOR   = 5'd5,
    CMD_OR    = 5'd6,
    CMD_CP    = 5'd7,
    CMD_INC8  = 5'd8,
    CMD_DEC8  = 5'd9,
    CMD_ADD16 = 5'd10,
    CMD_INC16 = 5'd11,
    CMD_DEC16 = 5'd12,
    CMD_RLC   = 5'd13,
    CMD_RRC   = 5'd14,
    CMD_RL    = 5'd15,
    CMD_RR    = 5'd16,
    CMD_SLA   = 5'd17,
    CMD_SRA   = 5'd18,
    CMD_SWAP  = 5'd19,
    CMD_SRL   = 5'd20,
    CMD_BIT   = 5'd21,
    CMD_RES   = 5'd22,
    CMD_SET   = 5'd23
  } cmd_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

FILE: rtl/core/cafl_alu.sv
// Combinational datapath of the ALU: result, write-back enable and new flags.
// Depends on cafl_pkg for the operation codes and the flag bundle.
module cafl_alu import cafl_pkg::*; (
  input  logic [CmdWidth-1:0]  cmd_i,
  input  logic [WordWidth-1:0] operand_a_i,
  input  logic [WordWidth-1:0] operand_b_i,
  input  logic [IdxWidth-1:0]  bit_index_i,
  input  flags_t               flags_i,
  output logic [WordWidth-1:0] result_o,
  output logic                 writes_back_o,
  output flags_t               flags_o
);

  logic [ByteWidth-1:0] a;
  logic [ByteWidth-1:0] b;
  logic                 cin;
  logic [ByteWidth:0]   add9;
  logic [ByteWidth:0]   sub9;
  logic [4:0]           add_nib;
  logic [4:0]           sub_nib;
  logic                 cin_sel;
  logic [WordWidth:0]   add17;
  logic [12:0]          add13;
  logic [ByteWidth-1:0] mask;
  logic [ByteWidth-1:0] r8;

  assign a       = operand_a_i[ByteWidth-1:0];
  assign b       = operand_b_i[ByteWidth-1:0];
  assign cin     = flags_i.c;
  assign cin_sel = (cmd_i == CMD_ADC || cmd_i == CMD_SBC) ? cin : 1'b0;
  assign add9    = {1'b0, a} + {1'b0, b} + {{ByteWidth{1'b0}}, cin_sel};
  assign sub9    = {1'b0, a} - {1'b0, b} - {{ByteWidth{1'b0}}, cin_sel};
  assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_sel};
  assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sel};
  assign add17   = {1'b0, operand_a_i} + {1'b0, operand_b_i};
  assign add13   = {1'b0, operand_a_i[11:0]} + {1'b0, operand_b_i[11:0]};
  assign mask    = ByteWidth'(1) << bit_index_i;

  always_comb begin
    r8            = a;
    result_o      = operand_a_i;
    writes_back_o = 1'b1;
    flags_o       = flags_i;
    case (cmd_i)
      CMD_ADD, CMD_ADC: begin
        r8      = add9[ByteWidth-1:0];
        flags_o = '{z: (r8 == '0), n: 1'b0, h: add_nib[4], c: add9[ByteWidth]};
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        r8            = sub9[ByteWidth-1:0];
        flags_o       = '{z: (r8 == '0), n: 1'b1, h: sub_nib[4], c: sub9[ByteWidth]};
        writes_back_o = (cmd_i != CMD_CP);
      end
      CMD_AND: begin
        r8      = a & b;
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      CMD_XOR: begin
        r8      = a ^ b;
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_OR: begin
        r8      = a | b;
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_INC8: begin
        r8      = a + 8'd1;
        flags_o = '{z: (r8 == '0), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
      end
      CMD_DEC8: begin
        r8      = a - 8'd1;
        flags_o = '{z: (r8 == '0), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
      end
      CMD_RLC: begin
        r8      = {a[6:0], a[7]};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      CMD_RRC: begin
        r8      = {a[0], a[7:1]};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_RL: begin
        r8      = {a[6:0], cin};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      CMD_RR: begin
        r8      = {cin, a[7:1]};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_SLA: begin
        r8      = {a[6:0], 1'b0};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      CMD_SRA: begin
        r8      = {a[7], a[7:1]};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_SWAP: begin
        r8      = {a[3:0], a[7:4]};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_SRL: begin
        r8      = {1'b0, a[7:1]};
        flags_o = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_BIT: begin
        writes_back_o = 1'b0;
        flags_o       = '{z: ~a[bit_index_i], n: 1'b0, h: 1'b1, c: cin};
      end
      CMD_RES: r8 = a & ~mask;
      CMD_SET: r8 = a | mask;
      default: r8 = a;
    endcase

    case (cmd_i)
      CMD_ADD16: begin
        result_o = add17[WordWidth-1:0];
        flags_o  = '{z: flags_i.z, n: 1'b0, h: add13[12], c: add17[WordWidth]};
      end
      CMD_INC16: result_o = operand_a_i + 16'd1;
      CMD_DEC16: result_o = operand_a_i - 16'd1;
      CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBC, CMD_AND, CMD_XOR, CMD_OR, CMD_CP,
      CMD_INC8, CMD_DEC8, CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA,
      CMD_SWAP, CMD_SRL, CMD_BIT, CMD_RES, CMD_SET: begin
        result_o = {{(WordWidth-ByteWidth){1'b0}}, r8};
      end
      default: begin
        // Unassigned codes pass operand A through and touch no flag.
        result_o      = operand_a_i;
        writes_back_o = 1'b0;
        flags_o       = flags_i;
      end
    endcase
  end

endmodule

FILE: rtl/core/cpu_alu_with_flags_core.sv
// Top level of the 8-bit ALU with a stored Z/N/H/C flag register.
// Depends on cafl_pkg and cafl_alu.
//
// Each operation passes through an input register and then a result register on
// its way to the output, and a new operation can be taken in every cycle while
// the result side is not stalled. This throughput of one operation per cycle is
// set by the flag loop: the flag register is updated when an operation moves
// into the result register and feeds the next operation straight away. The flag
// outputs are read from that flag register, which is cleared by reset.
module cpu_alu_with_flags_core import cafl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CmdWidth-1:0]  cmd_i,
  input  logic [WordWidth-1:0] operand_a_i,
  input  logic [WordWidth-1:0] operand_b_i,
  input  logic [IdxWidth-1:0]  bit_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WordWidth-1:0] result_o,
  output logic                 writes_back_o,
  output logic                 zero_flag_o,
  output logic                 subtract_flag_o,
  output logic                 half_carry_flag_o,
  output logic                 carry_flag_o
);

  logic                 in_valid_q;
  logic [CmdWidth-1:0]  cmd_q;
  logic [WordWidth-1:0] operand_a_q;
  logic [WordWidth-1:0] operand_b_q;
  logic [IdxWidth-1:0]  bit_index_q;

  logic                 out_valid_q;
  logic [WordWidth-1:0] result_q;
  logic [WordWidth-1:0] result_d;
  logic                 writes_back_q;
  logic                 writes_back_d;
  flags_t               flags_q;
  flags_t               flags_d;

  logic                 out_load;
  logic                 in_load;

  // The result register loads when it is empty or its transfer completes.
  assign out_load   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~out_load;
  assign in_load    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q       <= cmd_i;
      operand_a_q <= operand_a_i;
      operand_b_q <= operand_b_i;
      bit_index_q <= bit_index_i;
    end
  end

  cafl_alu u_alu (
    .cmd_i         (cmd_q),
    .operand_a_i   (operand_a_q),
    .operand_b_i   (operand_b_q),
    .bit_index_i   (bit_index_q),
    .flags_i       (flags_q),
    .result_o      (result_d),
    .writes_back_o (writes_back_d),
    .flags_o       (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      result_q      <= result_d;
      writes_back_q <= writes_back_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_o          = result_q;
  assign writes_back_o     = writes_back_q;
  assign zero_flag_o       = flags_q.z;
  assign subtract_flag_o   = flags_q.n;
  assign half_carry_flag_o = flags_q.h;
  assign carry_flag_o      = flags_q.c;

endmodule

FILE: tb/alu_flags_checker.sv
// Checker for the 8-bit ALU with flag register: predicts every result and compares it.
// Depends on cafl_pkg; watches both channels of cpu_alu_with_flags_core beside it.
module alu_flags_checker import cafl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CmdWidth-1:0]  cmd_i,
  input  logic [WordWidth-1:0] operand_a_i,
  input  logic [WordWidth-1:0] operand_b_i,
  input  logic [IdxWidth-1:0]  bit_index_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [WordWidth-1:0] result_i,
  input  logic                 writes_back_i,
  input  logic                 zero_flag_i,
  input  logic                 subtract_flag_i,
  input  logic                 half_carry_flag_i,
  input  logic                 carry_flag_i,
  output int                   failures_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [WordWidth-1:0] result;
    logic                 writes_back;
    flags_t               flags;
  } alu_outcome_t;

  alu_outcome_t expected_results[$];
  flags_t       flag_reg;
  int           fail_count;

  function automatic flags_t mk_flags(input logic z, input logic n, input logic h,
                                      input logic c);
    flags_t f;
    f.z = z;
    f.n = n;
    f.h = h;
    f.c = c;
    return f;
  endfunction

  function automatic alu_outcome_t predict_alu(input logic [CmdWidth-1:0] cmd,
                                               input logic [WordWidth-1:0] a16,
                                               input logic [WordWidth-1:0] b16,
                                               input logic [IdxWidth-1:0] idx,
                                               input flags_t fl);
    alu_outcome_t o;
    logic [7:0]   a;
    logic [7:0]   b;
    logic [7:0]   r8;
    logic [8:0]   t9;
    logic [4:0]   t5;
    logic [16:0]  t17;
    logic [12:0]  t13;
    logic         cin;
    logic         byte_op;
    a = a16[7:0];
    b = b16[7:0];
    cin = fl.c;
    r8 = 8'h00;
    byte_op = 1'b1;
    o.result = a16;
    o.writes_back = 1'b1;
    o.flags = fl;
    case (cmd)
      CMD_ADD, CMD_ADC: begin
        t9 = {1'b0, a} + {1'b0, b} + ((cmd == CMD_ADC) ? {8'd0, cin} : 9'd0);
        t5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + ((cmd == CMD_ADC) ? {4'd0, cin} : 5'd0);
        r8 = t9[7:0];
        o.flags = mk_flags(r8 == 8'h00, 1'b0, t5[4], t9[8]);
      end
      CMD_SUB, CMD_CP: begin
        r8 = a - b;
        o.flags = mk_flags(r8 == 8'h00, 1'b1, a[3:0] < b[3:0], a < b);
        if (cmd == CMD_CP) begin
          o.writes_back = 1'b0;
        end
      end
      CMD_SBC: begin
        r8 = a - b - {7'd0, cin};
        o.flags = mk_flags(r8 == 8'h00, 1'b1,
                           {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin}),
                           {1'b0, a} < ({1'b0, b} + {8'd0, cin}));
      end
      CMD_AND: begin
        r8 = a & b;
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      CMD_XOR: begin
        r8 = a ^ b;
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_OR: begin
        r8 = a | b;
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_INC8: begin
        r8 = a + 8'd1;
        o.flags = mk_flags(r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
      end
      CMD_DEC8: begin
        r8 = a - 8'd1;
        o.flags = mk_flags(r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
      end
      CMD_ADD16: begin
        byte_op = 1'b0;
        t17 = {1'b0, a16} + {1'b0, b16};
        t13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        o.result = t17[15:0];
        o.flags = mk_flags(fl.z, 1'b0, t13[12], t17[16]);
      end
      CMD_INC16: begin
        byte_op = 1'b0;
        o.result = a16 + 16'd1;
      end
      CMD_DEC16: begin
        byte_op = 1'b0;
        o.result = a16 - 16'd1;
      end
      CMD_RLC: begin
        r8 = {a[6:0], a[7]};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      CMD_RRC: begin
        r8 = {a[0], a[7:1]};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      CMD_RL: begin
        r8 = {a[6:0], cin};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      CMD_RR: begin
        r8 = {cin, a[7:1]};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      CMD_SLA: begin
        r8 = {a[6:0], 1'b0};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      CMD_SRA: begin
        r8 = {a[7], a[7:1]};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      CMD_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_SRL: begin
        r8 = {1'b0, a[7:1]};
        o.flags = mk_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      CMD_BIT: begin
        r8 = a;
        o.writes_back = 1'b0;
        o.flags = mk_flags(~a[idx], 1'b0, 1'b1, cin);
      end
      CMD_RES: begin
        r8 = a & ~(8'd1 << idx);
      end
      CMD_SET: begin
        r8 = a | (8'd1 << idx);
      end
      default: begin
        // Unused codes pass operand A through and leave the flags alone.
        byte_op = 1'b0;
        o.writes_back = 1'b0;
      end
    endcase
    if (byte_op) begin
      o.result = {8'h00, r8};
    end
    return o;
  endfunction

  task automatic check_field(input string name, input logic [WordWidth-1:0] want,
                             input logic [WordWidth-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alu_outcome_t want;
    if (!rst_ni) begin
      expected_results.delete();
      flag_reg = '0;
      fail_count = 0;
      failures_o <= 0;
      pending_o <= 0;
    end else begin
      // The result side is checked first, so a transfer out never meets an
      // expectation pushed at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_i);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result", want.result, result_i);
          check_field("writes_back", 16'(want.writes_back), 16'(writes_back_i));
          check_field("zero_flag", 16'(want.flags.z), 16'(zero_flag_i));
          check_field("subtract_flag", 16'(want.flags.n), 16'(subtract_flag_i));
          check_field("half_carry_flag", 16'(want.flags.h), 16'(half_carry_flag_i));
          check_field("carry_flag", 16'(want.flags.c), 16'(carry_flag_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_alu(cmd_i, operand_a_i, operand_b_i, bit_index_i, flag_reg);
        flag_reg = want.flags;
        expected_results.push_back(want);
      end
      failures_o <= fail_count;
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Top of the testbench for cpu_alu_with_flags_core: clock, reset, stimulus and verdict.
// Depends on cafl_pkg, the block itself and alu_flags_checker, which does the checking.
module tb_top;
  import cafl_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 60;
  localparam logic [CmdWidth-1:0] CmdTopCode = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CmdWidth-1:0]  cmd_i;
  logic [WordWidth-1:0] operand_a_i;
  logic [WordWidth-1:0] operand_b_i;
  logic [IdxWidth-1:0]  bit_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [WordWidth-1:0] result_o;
  logic                 writes_back_o;
  logic                 zero_flag_o;
  logic                 subtract_flag_o;
  logic                 half_carry_flag_o;
  logic                 carry_flag_o;

  int failures;
  int pending;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;
  int hold_done = 0;
  int hold_left = 0;
  int cycle_count = 0;

  cpu_alu_with_flags_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .operand_a_i       (operand_a_i),
    .operand_b_i       (operand_b_i),
    .bit_index_i       (bit_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_o          (result_o),
    .writes_back_o     (writes_back_o),
    .zero_flag_o       (zero_flag_o),
    .subtract_flag_o   (subtract_flag_o),
    .half_carry_flag_o (half_carry_flag_o),
    .carry_flag_o      (carry_flag_o)
  );

  alu_flags_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .cmd_i             (cmd_i),
    .operand_a_i       (operand_a_i),
    .operand_b_i       (operand_b_i),
    .bit_index_i       (bit_index_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_i          (result_o),
    .writes_back_i     (writes_back_o),
    .zero_flag_i       (zero_flag_o),
    .subtract_flag_i   (subtract_flag_o),
    .half_carry_flag_i (half_carry_flag_o),
    .carry_flag_i      (carry_flag_o),
    .failures_o        (failures),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("cpu_alu_with_flags_core verification failed");
      $finish;
    end
  end

  // A requested hold-off keeps the result side stalled for a long stretch.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_reqs != hold_done) begin
      hold_done++;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_op(input logic [CmdWidth-1:0] cmd, input logic [WordWidth-1:0] a,
                         input logic [WordWidth-1:0] b, input logic [IdxWidth-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    bit_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [WordWidth-1:0] pick_word();
    logic [WordWidth-1:0] corners[6];
    corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h000F, 16'h0FFF};
    if ($urandom_range(7) == 0) begin
      return corners[$urandom_range(5)];
    end
    return WordWidth'($urandom);
  endfunction

  task automatic send_random_ops(input int count);
    logic [CmdWidth-1:0] cmd;
    repeat (count) begin
      if ($urandom_range(99) < 90) begin
        cmd = CmdWidth'($urandom_range(CMD_SET));
      end else begin
        cmd = CmdWidth'($urandom_range(CmdTopCode, CMD_SET + 1));
      end
      send_op(cmd, pick_word(), pick_word(), IdxWidth'($urandom_range(7)));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    bit_index_i = '0;
    tx_idle_pct = 10;
    rx_idle_pct = 66;
    hold_reqs   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every operation at its edges, with flags carried between them.
    send_op(CMD_ADD,   16'h00FF, 16'h0001, 3'd0);
    send_op(CMD_ADC,   16'h000F, 16'h00F0, 3'd0);
    send_op(CMD_SUB,   16'h0000, 16'h0001, 3'd0);
    send_op(CMD_SBC,   16'h0010, 16'h000F, 3'd0);
    send_op(CMD_AND,   16'hFFFF, 16'h0000, 3'd0);
    send_op(CMD_XOR,   16'h00A5, 16'h00A5, 3'd0);
    send_op(CMD_OR,    16'h0000, 16'hFFFF, 3'd0);
    send_op(CMD_CP,    16'h0042, 16'h0042, 3'd0);
    send_op(CMD_INC8,  16'hFFFF, 16'h0000, 3'd0);
    send_op(CMD_DEC8,  16'h0100, 16'h0000, 3'd0);
    send_op(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0);
    send_op(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0);
    send_op(CMD_INC16, 16'hFFFF, 16'h0000, 3'd0);
    send_op(CMD_DEC16, 16'h0000, 16'hFFFF, 3'd0);
    send_op(CMD_RLC,   16'h0080, 16'h0000, 3'd0);
    send_op(CMD_RRC,   16'h0001, 16'h0000, 3'd0);
    send_op(CMD_RL,    16'h0080, 16'h0000, 3'd0);
    send_op(CMD_RR,    16'h0001, 16'h0000, 3'd0);
    send_op(CMD_SLA,   16'h0080, 16'h0000, 3'd0);
    send_op(CMD_SRA,   16'h0081, 16'h0000, 3'd0);
    send_op(CMD_SWAP,  16'h00F0, 16'h0000, 3'd0);
    send_op(CMD_SRL,   16'h0001, 16'h0000, 3'd0);
    send_op(CMD_BIT,   16'h007F, 16'h0000, 3'd7);
    send_op(CMD_RES,   16'h00FF, 16'h0000, 3'd0);
    send_op(CMD_SET,   16'hFF00, 16'h0000, 3'd7);
    send_op(CmdTopCode, 16'hFFFF, 16'hFFFF, 3'd7);
    wait_drained();

    send_random_ops(135);
    wait_drained();

    tx_idle_pct = 66;
    rx_idle_pct = 10;
    send_random_ops(135);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    send_random_ops(130);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("cpu_alu_with_flags_core verification clean");
    end else begin
      $display("cpu_alu_with_flags_core verification failed");
    end
    $finish;
  end

endmodule
